/* src/per_side_fifo_queues_macros.svh */
// assertion macros shared by the per-side queue block
// needs clk_i and rst_ni in the scope where the macros are used
`ifndef PER_SIDE_FIFO_QUEUES_MACROS_SVH
`define PER_SIDE_FIFO_QUEUES_MACROS_SVH

// same-cycle implication, sampled on the rising clock, off during reset
`define PSFQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PSFQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/psfq_pkg.sv */
// shared constants for the per-side queue block: operation and status codes,
// fixed port widths; no dependencies
package psfq_pkg;

  localparam int unsigned DATA_W  = 64;
  localparam int unsigned FILL_W  = 5;
  localparam int unsigned MASK_W  = 4;
  localparam int unsigned OP_W    = 2;
  localparam int unsigned SIDE_W  = 2;
  localparam int unsigned STAT_W  = 2;

  typedef logic [OP_W-1:0]   op_t;
  typedef logic [STAT_W-1:0] status_t;

  localparam op_t OP_PUSH  = 2'd0;
  localparam op_t OP_POP   = 2'd1;
  localparam op_t OP_CLEAR = 2'd2;

  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_DISABLED = 2'd1;
  localparam status_t ST_FULL     = 2'd2;
  localparam status_t ST_EMPTY    = 2'd3;

endpackage

/* src/psfq_ram.sv */
// generic simple dual-port ram: one write port, one read port, registered read
// no dependencies
module psfq_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/per_side_fifo_queues.sv */
// per-side fifo queues: ring buffers in one shared entry ram, per-side head and count
// depends on psfq_pkg, psfq_ram and per_side_fifo_queues_macros.svh
//
//  channel   dir   handshake                  beat
//  command   in    start & !busy              operation_i, side_i, payload_i
//  config    in    cfg_valid_i & cfg_ready_o  cfg_data_i (disable mask)
//  result    out   result_valid_o strobe      status_o, popped_data_o,
//                                             fill_count_o, side_disabled_o
//
// one command per cycle; its result shows in the cycle after acceptance, as
// the result fields and the read port of the entry ram are registered.
// busy stays low, so commands may follow back to back.
// reset clears heads, counts and the mask at once; the entry ram is not cleared.
// the receiver cannot stall: each result is shown for exactly one cycle.
`include "per_side_fifo_queues_macros.svh"

module per_side_fifo_queues
  import psfq_pkg::*;
#(
  parameter int unsigned SIDES       = 4,
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned ENTRY_WIDTH = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [OP_W-1:0]   operation_i,
  input  logic [SIDE_W-1:0] side_i,
  input  logic [DATA_W-1:0] payload_i,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [MASK_W-1:0] cfg_data_i,
  output logic              result_valid_o,
  output logic [STAT_W-1:0] status_o,
  output logic [DATA_W-1:0] popped_data_o,
  output logic [FILL_W-1:0] fill_count_o,
  output logic              side_disabled_o
);

  localparam int unsigned SIDX_W = (SIDES > 1) ? $clog2(SIDES) : 1;
  localparam int unsigned HEAD_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned SUM_W  = HEAD_W + 1;
  localparam int unsigned ADDR_W = $clog2(SIDES * QUEUE_DEPTH);

  logic [HEAD_W-1:0] head_q [SIDES];
  logic [HEAD_W-1:0] head_d [SIDES];
  logic [CNT_W-1:0]  cnt_q  [SIDES];
  logic [CNT_W-1:0]  cnt_d  [SIDES];
  logic [MASK_W-1:0] mask_q;

  logic              accept;
  logic              side_ok;
  logic [SIDX_W-1:0] sidx;
  logic [HEAD_W-1:0] head_cur;
  logic [CNT_W-1:0]  cnt_cur;
  logic              dis_cur;
  logic [SUM_W-1:0]  tail_sum;
  logic [HEAD_W-1:0] tail_slot;
  logic [HEAD_W-1:0] head_inc;
  logic [ADDR_W-1:0] side_base;
  logic              push_ok;
  logic              pop_ok;
  logic [CNT_W-1:0]  cnt_new;
  status_t           status_d;

  logic              valid_q;
  logic              pop_ok_q;
  status_t           status_q;
  logic [FILL_W-1:0] fill_q;
  logic              dis_q;
  logic [ENTRY_WIDTH-1:0] rdata;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  assign side_ok  = 32'(side_i) < SIDES;
  assign sidx     = SIDX_W'(side_i);
  assign head_cur = head_q[sidx];
  assign cnt_cur  = cnt_q[sidx];
  assign dis_cur  = mask_q[side_i];

  // ring slot after the last entry, wrapped with one compare and subtract
  always_comb begin
    tail_sum = SUM_W'(head_cur) + SUM_W'(cnt_cur);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
    end
    tail_slot = HEAD_W'(tail_sum);
  end

  assign head_inc  = (32'(head_cur) == QUEUE_DEPTH - 1) ? '0 : head_cur + HEAD_W'(1);
  assign side_base = ADDR_W'(32'(sidx) * QUEUE_DEPTH);

  assign push_ok = accept && side_ok && (operation_i == OP_PUSH) && !dis_cur &&
                   (32'(cnt_cur) < QUEUE_DEPTH);
  assign pop_ok  = accept && side_ok && (operation_i == OP_POP) && (cnt_cur != '0);

  always_comb begin
    for (int s = 0; s < SIDES; s++) begin
      head_d[s] = head_q[s];
      cnt_d[s]  = cnt_q[s];
    end
    cnt_new  = cnt_cur;
    status_d = ST_OK;
    if (side_ok) begin
      case (operation_i)
        OP_PUSH: begin
          if (dis_cur) begin
            status_d = ST_DISABLED;
          end else if (32'(cnt_cur) >= QUEUE_DEPTH) begin
            status_d = ST_FULL;
          end else begin
            cnt_new = cnt_cur + CNT_W'(1);
          end
        end
        OP_POP: begin
          if (cnt_cur == '0) begin
            status_d = ST_EMPTY;
          end else begin
            cnt_new = cnt_cur - CNT_W'(1);
          end
        end
        OP_CLEAR: begin
          cnt_new = '0;
        end
        default: begin
          cnt_new = cnt_cur;
        end
      endcase
    end else begin
      status_d = ST_DISABLED;
    end
    if (accept && side_ok) begin
      cnt_d[sidx] = cnt_new;
      if (pop_ok) begin
        head_d[sidx] = head_inc;
      end else if (operation_i == OP_CLEAR) begin
        head_d[sidx] = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < SIDES; s++) begin
        head_q[s] <= '0;
        cnt_q[s]  <= '0;
      end
      mask_q   <= '0;
      valid_q  <= 1'b0;
      pop_ok_q <= 1'b0;
    end else begin
      for (int s = 0; s < SIDES; s++) begin
        head_q[s] <= head_d[s];
        cnt_q[s]  <= cnt_d[s];
      end
      if (cfg_valid_i && cfg_ready_o) begin
        mask_q <= cfg_data_i;
      end
      valid_q  <= accept;
      pop_ok_q <= pop_ok;
    end
  end

  // result beat fields, qualified by valid_q
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      fill_q   <= side_ok ? FILL_W'(cnt_new) : '0;
      dis_q    <= side_ok ? dis_cur : 1'b1;
    end
  end

  psfq_ram #(
    .WIDTH (ENTRY_WIDTH),
    .DEPTH (SIDES * QUEUE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i (side_base + ADDR_W'(tail_slot)),
    .wdata_i (payload_i[ENTRY_WIDTH-1:0]),
    .raddr_i (side_base + ADDR_W'(head_cur)),
    .rdata_o (rdata)
  );

  assign result_valid_o  = valid_q;
  assign status_o        = status_q;
  assign fill_count_o    = fill_q;
  assign side_disabled_o = dis_q;
  assign popped_data_o   = pop_ok_q ? DATA_W'(rdata) : '0;

  `PSFQ_ASSERT_NEXT(a_result_follows, accept, result_valid_o,
                    "accepted command gave no result beat")
  `PSFQ_ASSERT_NOW(a_pop_data_zero, result_valid_o && status_o != ST_OK,
                   popped_data_o == '0, "refused command returned data")
  `PSFQ_ASSERT_NOW(a_full_count, result_valid_o && status_o == ST_FULL,
                   fill_count_o == FILL_W'(QUEUE_DEPTH), "full status with short queue")
  `PSFQ_ASSERT_NOW(a_empty_count, result_valid_o && status_o == ST_EMPTY,
                   fill_count_o == '0, "empty status with entries held")
  `PSFQ_ASSERT_NOW(a_count_bound, 1'b1, 32'(cnt_cur) <= QUEUE_DEPTH,
                   "queue count beyond depth")

endmodule
